// ----- design/ipv6f_pkg.sv -----
package ipv6f_pkg;

  // address shape
  localparam int unsigned GroupCount = 8;
  localparam int unsigned GroupW     = 16;
  localparam int unsigned StartW     = $clog2(GroupCount);
  localparam int unsigned LenW       = $clog2(GroupCount + 1);
  localparam int unsigned CharW      = 7;
  localparam int unsigned NibSelW    = 2;

  // character codes
  localparam logic [CharW-1:0] ColonChar  = 7'h3A;
  localparam logic [CharW-1:0] DigitZero  = 7'h30;
  localparam logic [CharW-1:0] LetterA    = 7'h61;

  // group index one past the last group, and index of the last group
  localparam logic [LenW-1:0] GroupEnd  = LenW'(GroupCount);
  localparam logic [LenW-1:0] GroupLast = LenW'(GroupCount - 1);

  typedef logic [GroupW-1:0] group_t;

  // classified address handed from front to back
  typedef struct packed {
    group_t [GroupCount-1:0] groups;
    logic   [StartW-1:0]     run_start;
    logic   [LenW-1:0]       run_len;
  } desc_t;

  // index of the top nonzero nibble, zero for a zero group
  function automatic logic [NibSelW-1:0] lead_nib(input group_t v);
    logic [NibSelW-1:0] r;
    if (v[15:12] != 4'd0) begin
      r = 2'd3;
    end else if (v[11:8] != 4'd0) begin
      r = 2'd2;
    end else if (v[7:4] != 4'd0) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

  // lower-case hex digit
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] r;
    if (nib < 4'd10) begin
      r = DigitZero + CharW'(nib);
    end else begin
      r = LetterA + CharW'(nib - 4'd10);
    end
    return r;
  endfunction

endpackage

// ----- design/ipv6f_front.sv -----
module ipv6f_front import ipv6f_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  group_t [GroupCount-1:0] groups_i,
  output logic                    q_push_o,
  output desc_t                   q_desc_o,
  input  logic                    q_full_i
);

  logic                    valid_q, valid_d;
  group_t [GroupCount-1:0] groups_q;
  logic   [GroupCount-1:0] zero;
  logic   [StartW-1:0]     cur_start, best_start;
  logic   [LenW-1:0]       cur_len, best_len;
  logic                    accept;

  // input stage holds one address until the queue takes it
  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q && !q_full_i;
  assign valid_d  = accept ? 1'b1 : (valid_q && q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      groups_q <= groups_i;
    end
  end

  // first longest run of zero groups
  always_comb begin
    cur_start  = '0;
    cur_len    = '0;
    best_start = '0;
    best_len   = '0;
    for (int i = 0; i < GroupCount; i++) begin
      zero[i] = (groups_q[i] == '0);
      if (zero[i]) begin
        if (cur_len == '0) begin
          cur_start = StartW'(i);
        end
        cur_len = cur_len + 1'b1;
      end else begin
        if (cur_len > best_len) begin
          best_start = cur_start;
          best_len   = cur_len;
        end
        cur_len = '0;
      end
    end
    // run reaching the last group
    if (cur_len > best_len) begin
      best_start = cur_start;
      best_len   = cur_len;
    end
  end

  assign q_desc_o.groups    = groups_q;
  assign q_desc_o.run_start = best_start;
  assign q_desc_o.run_len   = best_len;

endmodule

// ----- design/ipv6f_queue.sv -----
module ipv6f_queue import ipv6f_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t rdata_o,
  output logic  empty_o
);

  desc_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  count_q;
  logic        do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/ipv6f_back.sv -----
module ipv6f_back import ipv6f_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  desc_t            q_desc_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [CharW-1:0] char_code_o,
  output logic             last_char_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD,
    S_RUN,
    S_DIGIT,
    S_SEP
  } phase_e;

  phase_e             phase_q, phase_d, ent_phase;
  desc_t              desc_q, desc_d, ent_desc;
  logic [LenW-1:0]    grp_q, grp_d, ent_g, run_end;
  logic [NibSelW-1:0] nib_q, nib_d, ent_nib;
  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   char_q, char_d;
  logic               last_q, last_d;
  logic               adv, load, emit, ent_run;
  group_t             cur_group;
  logic [3:0]         cur_nib;

  assign adv     = !out_valid_q || pop_i;
  assign load    = (phase_q == S_IDLE) && !q_empty_i;
  assign q_pop_o = load;
  assign emit    = (phase_q != S_IDLE) && adv;
  assign run_end = LenW'(desc_q.run_start) + desc_q.run_len;

  // entry into the next group
  always_comb begin
    ent_desc = load ? q_desc_i : desc_q;
    case (phase_q)
      S_IDLE:  ent_g = '0;
      S_RUN:   ent_g = run_end;
      S_SEP:   ent_g = grp_q + 1'b1;
      default: ent_g = grp_q;
    endcase
    ent_run   = (ent_desc.run_len != '0) && (ent_g == LenW'(ent_desc.run_start));
    ent_phase = ent_run ? ((ent_g == '0) ? S_LEAD : S_RUN) : S_DIGIT;
    ent_nib   = lead_nib(ent_desc.groups[ent_g[StartW-1:0]]);
  end

  // current digit
  assign cur_group = desc_q.groups[grp_q[StartW-1:0]];
  assign cur_nib   = 4'(cur_group >> {nib_q, 2'b00});

  // character sequencer
  always_comb begin
    phase_d     = phase_q;
    desc_d      = desc_q;
    grp_d       = grp_q;
    nib_d       = nib_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (adv) begin
      out_valid_d = emit;
    end
    case (phase_q)
      S_IDLE: begin
        if (load) begin
          desc_d  = q_desc_i;
          phase_d = ent_phase;
          grp_d   = ent_g;
          nib_d   = ent_nib;
        end
      end
      S_LEAD: begin
        if (adv) begin
          char_d  = ColonChar;
          last_d  = 1'b0;
          phase_d = S_RUN;
        end
      end
      S_RUN: begin
        if (adv) begin
          char_d = ColonChar;
          last_d = (run_end == GroupEnd);
          if (run_end == GroupEnd) begin
            phase_d = S_IDLE;
          end else begin
            phase_d = ent_phase;
            grp_d   = ent_g;
            nib_d   = ent_nib;
          end
        end
      end
      S_DIGIT: begin
        if (adv) begin
          char_d = hex_char(cur_nib);
          last_d = (nib_q == '0) && (grp_q == GroupLast);
          if (nib_q != '0) begin
            nib_d = nib_q - 1'b1;
          end else if (grp_q == GroupLast) begin
            phase_d = S_IDLE;
          end else begin
            phase_d = S_SEP;
          end
        end
      end
      S_SEP: begin
        if (adv) begin
          char_d  = ColonChar;
          last_d  = 1'b0;
          phase_d = ent_phase;
          grp_d   = ent_g;
          nib_d   = ent_nib;
        end
      end
      default: begin
        phase_d = S_IDLE;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      desc_q      <= '0;
      grp_q       <= '0;
      nib_q       <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      desc_q      <= desc_d;
      grp_q       <= grp_d;
      nib_q       <= nib_d;
      char_q      <= char_d;
      last_q      <= last_d;
    end
  end

  assign empty_o     = !out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

`ifndef SYNTHESIS
  // a leading colon only for a run that opens the address
  a_lead_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == S_LEAD |-> desc_q.run_start == '0 && desc_q.run_len != '0)
    else $error("leading colon without a run at the first group");

  // digits only come from a real group
  a_digit_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == S_DIGIT |-> grp_q < GroupEnd)
    else $error("digit phase past the last group");

  // the final character closes the address
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && last_d |=> phase_q == S_IDLE && out_valid_q && last_q)
    else $error("sequencer kept running after the last character");
`endif

endmodule

// ----- design/ipv6_address_text_formatter_top.sv -----
// channel  direction  handshake          beat
// address  in         push / full        group_0_i .. group_7_i
// text     out        empty / pop        char_code_o, last_char_o
//
// an address waits in the input stage, where the zero-run search runs, until the queue takes it
// the sequencer then loads it and emits one character per cycle while pop is not held off,
// so an address with n characters (2 to 39) occupies it until its last character is sent
// a two-entry queue between search and sequencer absorbs stalls on either side
// a held-off pop stalls the sequencer only; full rises once the queue and input stage fill
// reset clears all valid flags and returns the sequencer to idle
module ipv6_address_text_formatter_top import ipv6f_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  group_t           group_0_i,
  input  group_t           group_1_i,
  input  group_t           group_2_i,
  input  group_t           group_3_i,
  input  group_t           group_4_i,
  input  group_t           group_5_i,
  input  group_t           group_6_i,
  input  group_t           group_7_i,
  output logic             empty,
  input  logic             pop,
  output logic [CharW-1:0] char_code_o,
  output logic             last_char_o
);

  group_t [GroupCount-1:0] groups;
  desc_t                   wdesc, rdesc;
  logic                    q_push, q_full, q_pop, q_empty;

  assign groups = {group_7_i, group_6_i, group_5_i, group_4_i,
                   group_3_i, group_2_i, group_1_i, group_0_i};

  // zero-run search
  ipv6f_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .groups_i (groups),
    .q_push_o (q_push),
    .q_desc_o (wdesc),
    .q_full_i (q_full)
  );

  // decoupling queue
  ipv6f_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (wdesc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (rdesc),
    .empty_o (q_empty)
  );

  // character sequencer
  ipv6f_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_desc_i    (rdesc),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

// ----- bench/ipv6_text_checker.sv -----
`timescale 1ns / 100ps

module ipv6_text_checker import ipv6f_pkg::*; (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  input  logic                               full,
  input  logic [GroupCount-1:0][GroupW-1:0]  groups_i,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [CharW-1:0]                   char_code_i,
  input  logic                               last_char_i,
  output int unsigned                        mismatch_count_o,
  output int unsigned                        chars_pending_o,
  output int unsigned                        addresses_taken_o,
  output int unsigned                        chars_checked_o
);

  typedef logic [GroupCount-1:0][GroupW-1:0] address_t;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  // ascii digits, '0' in the top byte
  localparam logic [127:0] HexDigits = "0123456789abcdef";

  text_char_t expected_text [$];

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what);
    $display("%0t text mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  // predicted text of one address, appended to the expected characters
  function automatic void format_address(input address_t grp);
    int unsigned      best_start;
    int unsigned      best_len;
    int unsigned      run_start;
    int unsigned      run_len;
    int unsigned      k;
    int               sh;
    logic [3:0]       nib;
    bit               lead;
    logic [CharW-1:0] text [$];
    text_char_t       c;
    best_start = 0;
    best_len   = 0;
    run_start  = 0;
    run_len    = 0;
    // first longest run of zero groups, a lone zero group included
    for (k = 0; k <= GroupCount; k++) begin
      if (k < GroupCount && grp[k] == '0) begin
        if (run_len == 0) run_start = k;
        run_len++;
      end else begin
        if (run_len > best_len) begin
          best_start = run_start;
          best_len   = run_len;
        end
        run_len = 0;
      end
    end
    // groups as hex without leading zeros, the chosen run as a double colon
    k = 0;
    while (k < GroupCount) begin
      if (best_len != 0 && k == best_start) begin
        if (k == 0) text.push_back(ColonChar);
        text.push_back(ColonChar);
        k += best_len;
      end else begin
        lead = 1'b0;
        for (sh = 3; sh >= 0; sh--) begin
          nib = grp[k][4*sh +: 4];
          if (nib != 4'd0 || lead || sh == 0) begin
            lead = 1'b1;
            text.push_back(HexDigits[8*(15-nib) +: CharW]);
          end
        end
        if (k < GroupCount - 1) text.push_back(ColonChar);
        k++;
      end
    end
    foreach (text[i]) begin
      c.code = text[i];
      c.last = (i == text.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  // watch both channels at each edge
  always @(posedge clk_i) begin
    text_char_t due;
    if (rst_ni) begin
      // text beat against the oldest expected character
      if (pop && !empty) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("char 0x%02h last %0b with nothing expected",
                                    char_code_i, last_char_i));
        end else begin
          due = expected_text.pop_front();
          if (char_code_i !== due.code) begin
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                      char_code_i, due.code));
          end
          if (last_char_i !== due.last) begin
            report_mismatch($sformatf("last_char %0b on char 0x%02h, expected %0b",
                                      last_char_i, due.code, due.last));
          end
          chars_checked_o <= chars_checked_o + 1;
        end
      end
      // address beat
      if (push && !full) begin
        format_address(groups_i);
        addresses_taken_o <= addresses_taken_o + 1;
      end
      chars_pending_o <= expected_text.size();
    end
  end

endmodule

// ----- bench/tb_ipv6_address_text_formatter_top.sv -----
`timescale 1ns / 100ps

module tb_ipv6_address_text_formatter_top;
  import ipv6f_pkg::*;

  typedef logic [GroupCount-1:0][GroupW-1:0] address_t;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned LongHold     = 600;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned PhaseItems   = 88;

  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             push      = 1'b0;
  logic             full;
  address_t         address   = '0;
  logic             empty;
  logic             pop       = 1'b0;
  logic [CharW-1:0] char_code_o;
  logic             last_char_o;

  int unsigned mismatch_count;
  int unsigned chars_pending;
  int unsigned addresses_taken;
  int unsigned chars_checked;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  logic        hold_req    = 1'b0;
  logic        hold_req_q  = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;

  ipv6_address_text_formatter_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .group_0_i   (address[0]),
    .group_1_i   (address[1]),
    .group_2_i   (address[2]),
    .group_3_i   (address[3]),
    .group_4_i   (address[4]),
    .group_5_i   (address[5]),
    .group_6_i   (address[6]),
    .group_7_i   (address[7]),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  ipv6_text_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .groups_i          (address),
    .empty             (empty),
    .pop               (pop),
    .char_code_i       (char_code_o),
    .last_char_i       (last_char_o),
    .mismatch_count_o  (mismatch_count),
    .chars_pending_o   (chars_pending),
    .addresses_taken_o (addresses_taken),
    .chars_checked_o   (chars_checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timed out after %0d cycles, %0d characters outstanding",
               cycle_count, chars_pending);
      $display("ipv6_address_text_formatter_top regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      hold_req_q <= 1'b0;
      hold_left  <= 0;
    end else begin
      hold_req_q <= hold_req;
      if (hold_req && !hold_req_q) begin
        hold_left <= LongHold;
        pop       <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic address_t make_address(input group_t g0, g1, g2, g3,
                                            input group_t g4, g5, g6, g7);
    return {g7, g6, g5, g4, g3, g2, g1, g0};
  endfunction

  // zero density varies per address so long runs and no runs both show up
  function automatic address_t random_address();
    address_t    a;
    int unsigned zero_pct;
    zero_pct = $urandom_range(80);
    for (int k = 0; k < GroupCount; k++) begin
      if ($urandom_range(99) < zero_pct) begin
        a[k] = '0;
      end else begin
        a[k] = group_t'($urandom >> (4 * $urandom_range(3)));
      end
    end
    return a;
  endfunction

  // one address beat, after a random idle gap
  task automatic send_address(input address_t addr);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    address <= addr;
    do @(posedge clk_i); while (full);
  endtask

  // stop sending and wait for every expected character
  task automatic wait_text_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_address(random_address());
  endtask

  // corner addresses
  task automatic send_directed();
    send_address(make_address(0, 0, 0, 0, 0, 0, 0, 0));
    send_address(make_address('hffff, 'hffff, 'hffff, 'hffff,
                              'hffff, 'hffff, 'hffff, 'hffff));
    send_address(make_address(1, 2, 3, 4, 5, 6, 7, 8));
    send_address(make_address(0, 0, 0, 1, 2, 3, 4, 5));
    send_address(make_address(1, 2, 3, 4, 5, 0, 0, 0));
    send_address(make_address(0, 1, 2, 3, 4, 5, 6, 7));
    send_address(make_address(1, 2, 3, 4, 5, 6, 7, 0));
    send_address(make_address('hffff, 0, 0, 0, 0, 0, 0, 0));
    send_address(make_address(0, 0, 0, 0, 0, 0, 0, 1));
    // tied runs, and a longer run after a shorter one
    send_address(make_address(1, 0, 0, 2, 0, 0, 3, 4));
    send_address(make_address(0, 1, 0, 0, 0, 2, 3, 4));
    send_address(make_address(0, 1, 0, 1, 0, 1, 0, 1));
    send_address(make_address('h8000, 0, 'h8000, 0, 0, 'h8000, 0, 0));
    send_address(make_address(0, 0, 0, 0, 1, 0, 0, 0));
    send_address(make_address(1, 0, 0, 0, 0, 0, 0, 2));
    send_address(make_address(1, 1, 1, 0, 0, 0, 0, 1));
    // digit counts and every hex digit
    send_address(make_address('h000f, 'h00f0, 'h0f00, 'hf000,
                              'h0001, 'h0010, 'h0100, 'h1000));
    send_address(make_address('habcd, 'hef01, 'h2345, 'h6789,
                              'h89ab, 'hcdef, 'hfedc, 'hba98));
  endtask

  // stimulus and verdict
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();
    wait_text_drained();

    // free running
    send_random(PhaseItems);
    wait_text_drained();

    // sender mostly idle
    idle_pct <= 83;
    send_random(PhaseItems);
    wait_text_drained();

    // receiver mostly stalled
    idle_pct  <= 0;
    stall_pct <= 83;
    send_random(PhaseItems);
    wait_text_drained();

    // both sides idle at times
    idle_pct  <= 31;
    stall_pct <= 31;
    send_random(PhaseItems);
    wait_text_drained();

    // long receiver hold-off while the sender keeps pushing until full
    idle_pct  <= 0;
    stall_pct <= 0;
    hold_req  <= 1'b1;
    send_random(PhaseItems);
    wait_text_drained();
    hold_req  <= 1'b0;

    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d addresses formatted, %0d characters checked, %0d mismatches",
             addresses_taken, chars_checked, mismatch_count);
    $display("covered corner addresses, free running, idle sender, stalled receiver,");
    $display("mixed gaps and a long hold-off with the input held full");
    if (mismatch_count == 0) begin
      $display("ipv6_address_text_formatter_top regression: pass");
    end else begin
      $display("ipv6_address_text_formatter_top regression: fail");
    end
    $finish;
  end

endmodule
